@@ rtl/core/channel_converter_function_decoder_core_macros.svh @@
// Assertion helpers used by the converter core RTL.
`ifndef CHANNEL_CONVERTER_FUNCTION_DECODER_CORE_MACROS_SVH
`define CHANNEL_CONVERTER_FUNCTION_DECODER_CORE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define CCFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define CCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CCFD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ccfd_pkg.sv @@
`timescale 1ns / 1ps
package ccfd_pkg;

  localparam int NUM_UNITS = 8;
  localparam int UNIT_W    = $clog2(NUM_UNITS);
  localparam int WORD_W    = 12;
  localparam int CFG_AW    = 3;

  // function codes
  localparam logic [WORD_W-1:0] FN_SELECT    = 12'o2000;
  localparam logic [WORD_W-1:0] FN_DESELECT  = 12'o2100;
  localparam logic [WORD_W-1:0] FN_CONN_DATA = 12'o1000;
  localparam logic [WORD_W-1:0] FN_FUNC_DATA = 12'o1100;
  localparam logic [WORD_W-1:0] FN_STATUS    = 12'o1200;
  localparam logic [WORD_W-1:0] FN_MCLEAR    = 12'o1700;
  localparam logic [WORD_W-1:0] FN_NONE      = 12'o0000;
  localparam logic [WORD_W-1:0] IO_MODE_LO   = 12'o1300;
  localparam logic [WORD_W-1:0] IO_MODE_HI   = 12'o1600;
  localparam logic [WORD_W-1:0] MODE_MASK    = 12'o7700;
  localparam logic [WORD_W-1:0] FUNC_MASK    = 12'o0777;

  // input op codes
  localparam logic [1:0] OP_FUNC  = 2'd0;
  localparam logic [1:0] OP_FULL  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_UNITS  = 1'b0;
  localparam logic REG_CONFIG = 1'b1;

  typedef enum logic [2:0] {
    R_DECLINED  = 3'd0,
    R_ACCEPTED  = 3'd1,
    R_PROCESSED = 3'd2,
    R_UNIT      = 3'd3,
    R_NONE      = 3'd4
  } reply_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_FUNC  = 2'd1,
    CMD_IO    = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [NUM_UNITS-1:0] present;
    logic                 configured;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [WORD_W-1:0]    word;
    logic [NUM_UNITS-1:0] intr;
  } item_t;

  typedef struct packed {
    logic              sel;
    logic              conn_valid;
    logic [UNIT_W-1:0] conn_unit;
    logic [WORD_W-1:0] pend;
    logic              rej;
  } state_t;

  typedef struct packed {
    reply_t            reply;
    cmd_t              cmd;
    logic [UNIT_W-1:0] target;
    logic [WORD_W-1:0] unit_word;
    logic [WORD_W-1:0] read_word;
    logic              read_valid;
    logic              consumed;
  } result_t;

  function automatic logic is_io_mode(input logic [WORD_W-1:0] code);
    logic [WORD_W-1:0] m;
    m = code & MODE_MASK;
    return (m >= IO_MODE_LO) && (m <= IO_MODE_HI);
  endfunction

endpackage

@@ rtl/core/channel_converter_function_decoder_core.sv @@
`timescale 1ns / 1ps
// Function decoder of a 12-bit channel converter serving up to eight units.
// Input channel (in_*): one item is a function word (op 0) or one channel
// data phase (op 1 full, op 2 empty), plus the units' interrupt flags.
// Result channel (out_*): exactly one result per item, in order: the reply
// code, a command for the attached units, and the status read or data-word
// consumption flags of a channel phase.
// Configuration: APB-style port, units_present at 0x0, converter_configured
// at 0x4; pready is tied high, writes land on the access cycle. Write it
// only while no item is in flight.
// Each accepted item is decoded combinationally from the input register
// into the result register. Throughput is one item per cycle while
// out_ready holds; the converter state is a single register set updated
// as items advance, so each item sees the state left by the one before.
// Stall: with out_ready low the result register holds and one further item
// waits in the input register; in_ready drops only when both are full.
// Reset (rst_n low, synchronous): both stages empty, the converter is
// selected with nothing connected or pending, status reject clear, no
// units present and the converter configured.
`include "channel_converter_function_decoder_core_macros.svh"
module channel_converter_function_decoder_core
  import ccfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [WORD_W-1:0]    in_word,
  input  logic [NUM_UNITS-1:0] in_unit_interrupts,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_reply,
  output logic [1:0]           out_unit_command,
  output logic [UNIT_W-1:0]    out_target_unit,
  output logic [WORD_W-1:0]    out_unit_word,
  output logic [WORD_W-1:0]    out_read_word,
  output logic                 out_read_valid,
  output logic                 out_word_consumed,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t res_r, res_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic    adv;

  // decode moves an item forward whenever the result slot is free or drains
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  ccfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccfd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg),
    .item  (item_r),
    .res   (res)
  );

  always_comb begin
    item_nxt   = item_r;
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      item_nxt.op   = in_op;
      item_nxt.word = in_word;
      item_nxt.intr = in_unit_interrupts;
      in_vld_nxt    = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end

    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      res_nxt     = res;
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_reply         = res_r.reply;
  assign out_unit_command  = res_r.cmd;
  assign out_target_unit   = res_r.target;
  assign out_unit_word     = res_r.unit_word;
  assign out_read_word     = res_r.read_word;
  assign out_read_valid    = res_r.read_valid;
  assign out_word_consumed = res_r.consumed;

  `CCFD_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid && in_ready,
                      "pipeline not empty after reset")
  `CCFD_ASSERT_IMP(a_phase_reply, out_valid && (out_read_valid || out_word_consumed),
                   out_reply == R_NONE, "channel phase result carries a function reply")
  `CCFD_ASSERT_IMP(a_phase_excl, out_valid, !(out_read_valid && out_word_consumed),
                   "status read and word consumption in one phase")
  `CCFD_ASSERT_IMP(a_cmd_clean,
                   out_valid && (out_unit_command == CMD_NONE || out_unit_command == CMD_CLEAR),
                   out_target_unit == '0 && out_unit_word == '0,
                   "unit fields set without an addressed command")
  `CCFD_ASSERT_NEXT(a_stall_full, in_vld_r && out_valid && !out_ready,
                    in_vld_r && out_valid, "stalled item lost while both stages are occupied")

endmodule

@@ rtl/core/ccfd_cfg.sv @@
`timescale 1ns / 1ps
module ccfd_cfg
  import ccfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [NUM_UNITS-1:0] present_r, present_nxt;
  logic                 configured_r, configured_nxt;
  logic                 wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    present_nxt    = present_r;
    configured_nxt = configured_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_UNITS:  present_nxt    = pwdata[NUM_UNITS-1:0];
        REG_CONFIG: configured_nxt = pwdata[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= '0;
      configured_r <= 1'b1;
    end else begin
      present_r    <= present_nxt;
      configured_r <= configured_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_UNITS:  prdata = {{(32-NUM_UNITS){1'b0}}, present_r};
      REG_CONFIG: prdata = {31'd0, configured_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.present    = present_r;
  assign cfg.configured = configured_r;

endmodule

@@ rtl/core/ccfd_decode.sv @@
`timescale 1ns / 1ps
module ccfd_decode
  import ccfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  state_t            st_r, st_nxt;
  logic              have;
  logic              full;
  logic [UNIT_W-1:0] top;

  assign have = st_r.conn_valid && cfg.present[st_r.conn_unit];
  assign full = (item.op == OP_FULL);
  assign top  = item.word[WORD_W-1 -: UNIT_W];

  always_comb begin
    st_nxt = st_r;
    res    = '0;
    res.reply = R_NONE;
    res.cmd   = CMD_NONE;
    unique case (item.op) inside
      OP_FUNC: begin
        if (!cfg.configured || (!st_r.sel && item.word != FN_SELECT)) begin
          res.reply = R_DECLINED;
        end else begin
          res.reply = R_PROCESSED;
          case (item.word) inside
            FN_SELECT: begin
              st_nxt.sel = 1'b1;
              st_nxt.rej = 1'b0;
            end
            FN_DESELECT: begin
              st_nxt.sel = 1'b0;
              st_nxt.rej = 1'b0;
            end
            FN_CONN_DATA, FN_FUNC_DATA, FN_STATUS: begin
              st_nxt.pend = item.word;
              res.reply   = R_ACCEPTED;
            end
            FN_MCLEAR: begin
              st_nxt.rej        = 1'b0;
              st_nxt.conn_valid = 1'b0;
              res.cmd           = CMD_CLEAR;
            end
            default: begin
              if (is_io_mode(item.word)) begin
                if (!have) begin
                  st_nxt.rej = 1'b1;
                end else begin
                  st_nxt.pend   = item.word;
                  res.cmd       = CMD_FUNC;
                  res.target    = st_r.conn_unit;
                  res.unit_word = item.word & MODE_MASK;
                  res.reply     = R_UNIT;
                end
              end else if (top[UNIT_W-1]) begin
                // direct connect, units in the upper half
                if (!cfg.present[top]) begin
                  st_nxt.rej = 1'b1;
                end else begin
                  st_nxt.conn_unit  = top;
                  st_nxt.conn_valid = 1'b1;
                  st_nxt.rej        = 1'b0;
                end
              end else if (top == '0) begin
                if (!have) begin
                  st_nxt.rej = 1'b1;
                end else begin
                  res.cmd       = CMD_FUNC;
                  res.target    = st_r.conn_unit;
                  res.unit_word = item.word & FUNC_MASK;
                  st_nxt.rej    = 1'b0;
                end
              end else begin
                st_nxt.rej = 1'b1;   // undefined code
              end
            end
          endcase
        end
      end
      OP_FULL, OP_EMPTY: begin
        if (st_r.pend == FN_CONN_DATA) begin
          if (full) begin
            res.consumed = 1'b1;
            if (!cfg.present[top]) begin
              st_nxt.rej = 1'b1;     // connect stays pending
            end else begin
              st_nxt.conn_unit  = top;
              st_nxt.conn_valid = 1'b1;
              st_nxt.pend       = FN_NONE;
              st_nxt.rej        = 1'b0;
            end
          end
        end else if (st_r.pend == FN_FUNC_DATA) begin
          if (full) begin
            res.consumed = 1'b1;
            st_nxt.pend  = FN_NONE;
            if (!have) begin
              st_nxt.rej = 1'b1;
            end else begin
              res.cmd       = CMD_FUNC;
              res.target    = st_r.conn_unit;
              res.unit_word = item.word;
            end
          end
        end else if (st_r.pend == FN_STATUS) begin
          if (!full) begin
            res.read_word  = {1'b0, cfg.present & item.intr, 1'b0, st_r.rej, st_r.rej};
            res.read_valid = 1'b1;
            st_nxt.pend    = FN_NONE;
          end
        end else if (is_io_mode(st_r.pend) && have) begin
          res.cmd       = CMD_IO;
          res.target    = st_r.conn_unit;
          res.unit_word = st_r.pend & MODE_MASK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.sel        <= 1'b1;
      st_r.conn_valid <= 1'b0;
      st_r.conn_unit  <= '0;
      st_r.pend       <= FN_NONE;
      st_r.rej        <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ dv/tb_channel_converter_function_decoder_core.sv @@
`timescale 1ns / 1ps
module tb_channel_converter_function_decoder_core;
  import ccfd_pkg::*;

  // op value the decoder ignores apart from a no-reply result
  localparam logic [1:0]        OP_SPARE        = 2'd3;
  // byte addresses: the register index sits in paddr[2]
  localparam logic [CFG_AW-1:0] ADDR_UNITS      = {REG_UNITS, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_CONFIG     = {REG_CONFIG, 2'b00};
  // status word: low two bits flag the reject, unit u lands on bit 3+u
  localparam logic [WORD_W-1:0] REJECT_STATUS   = 12'o0003;
  localparam int                UNIT_BIT0       = 3;
  // top digit of a direct connect code
  localparam logic [2:0]        DIRECT_UNIT_MIN = 3'd4;
  localparam int                MAX_GAP         = 14;
  localparam int                HOLD_CYCLES     = 200;
  localparam int                STALL_LIMIT     = 3000;
  localparam int                DRAIN_CYCLES    = 4;
  localparam int                MAX_REPORTS     = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_op = OP_FUNC;
  logic [WORD_W-1:0]    in_word = '0;
  logic [NUM_UNITS-1:0] in_unit_interrupts = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_reply;
  logic [1:0]           out_unit_command;
  logic [UNIT_W-1:0]    out_target_unit;
  logic [WORD_W-1:0]    out_unit_word;
  logic [WORD_W-1:0]    out_read_word;
  logic                 out_read_valid;
  logic                 out_word_consumed;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  channel_converter_function_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_word            (in_word),
    .in_unit_interrupts (in_unit_interrupts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply          (out_reply),
    .out_unit_command   (out_unit_command),
    .out_target_unit    (out_target_unit),
    .out_unit_word      (out_unit_word),
    .out_read_word      (out_read_word),
    .out_read_valid     (out_read_valid),
    .out_word_consumed  (out_word_consumed),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Converter model: register copies and decoder state, reset values.
  // ---------------------------------------------------------------------
  logic [NUM_UNITS-1:0] units_on = '0;
  logic                 conv_on = 1'b1;
  logic                 selected = 1'b1;
  logic                 linked = 1'b0;
  logic [UNIT_W-1:0]    linked_unit = '0;
  logic [WORD_W-1:0]    pending_fn = FN_NONE;
  logic                 reject_set = 1'b0;

  item_t   stim_items[$];        // items waiting to be offered
  result_t expected_results[$];  // predicted results, oldest first
  item_t   in_flight;            // item currently on the input port
  result_t want, got;

  int  fail_count = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic no_idle = 1'b0;

  // I/O modes 013..016 (octal) in the top two digits; low digits don't matter
  function automatic logic io_mode_code(input logic [WORD_W-1:0] code);
    return (code[11:9] == 3'd1) && (code[8:6] >= 3'd3) && (code[8:6] <= 3'd6);
  endfunction

  // a connection only counts while its unit is still present
  function automatic logic unit_linked();
    return linked && units_on[linked_unit];
  endfunction

  function automatic logic [NUM_UNITS-1:0] rand_intr();
    return NUM_UNITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom_range(0, 4095));
  endfunction

  // Works out the one result an item causes and advances the model state.
  function automatic result_t decode_item(input item_t it);
    result_t         r;
    logic [2:0]      top;
    logic [WORD_W-1:0] stat;
    r = '0;
    top = it.word[11:9];
    if (it.op == OP_FUNC) begin
      r.reply = R_PROCESSED;
      if (!conv_on || (!selected && it.word != FN_SELECT)) begin
        r.reply = R_DECLINED;
      end else if (it.word == FN_SELECT) begin
        selected = 1'b1;
        reject_set = 1'b0;
      end else if (it.word == FN_DESELECT) begin
        selected = 1'b0;
        reject_set = 1'b0;
      end else if (it.word == FN_CONN_DATA || it.word == FN_FUNC_DATA ||
                   it.word == FN_STATUS) begin
        // finished by a later channel phase
        pending_fn = it.word;
        r.reply = R_ACCEPTED;
      end else if (it.word == FN_MCLEAR) begin
        reject_set = 1'b0;
        linked = 1'b0;
        r.cmd = CMD_CLEAR;
      end else if (io_mode_code(it.word)) begin
        if (!unit_linked()) begin
          reject_set = 1'b1;
        end else begin
          pending_fn = it.word;
          r.cmd = CMD_FUNC;
          r.target = linked_unit;
          r.unit_word = it.word & MODE_MASK;
          r.reply = R_UNIT;
        end
      end else if (top >= DIRECT_UNIT_MIN) begin
        if (!units_on[top]) begin
          reject_set = 1'b1;
        end else begin
          linked_unit = top;
          linked = 1'b1;
          reject_set = 1'b0;
        end
      end else if (top == 3'd0) begin
        // nine-bit function straight to the connected unit
        if (!unit_linked()) begin
          reject_set = 1'b1;
        end else begin
          r.cmd = CMD_FUNC;
          r.target = linked_unit;
          r.unit_word = it.word & FUNC_MASK;
          reject_set = 1'b0;
        end
      end else begin
        // undefined code
        reject_set = 1'b1;
      end
    end else begin
      r.reply = R_NONE;
      if (it.op == OP_FULL || it.op == OP_EMPTY) begin
        if (pending_fn == FN_CONN_DATA) begin
          if (it.op == OP_FULL) begin
            r.consumed = 1'b1;
            // a failed connect keeps the connect pending
            if (!units_on[top]) begin
              reject_set = 1'b1;
            end else begin
              linked_unit = top;
              linked = 1'b1;
              pending_fn = FN_NONE;
              reject_set = 1'b0;
            end
          end
        end else if (pending_fn == FN_FUNC_DATA) begin
          if (it.op == OP_FULL) begin
            r.consumed = 1'b1;
            pending_fn = FN_NONE;
            if (!unit_linked()) begin
              reject_set = 1'b1;
            end else begin
              r.cmd = CMD_FUNC;
              r.target = linked_unit;
              r.unit_word = it.word;
            end
          end
        end else if (pending_fn == FN_STATUS) begin
          if (it.op == OP_EMPTY) begin
            stat = reject_set ? REJECT_STATUS : '0;
            for (int u = 0; u < NUM_UNITS; u++) begin
              if (units_on[u] && it.intr[u]) stat[u + UNIT_BIT0] = 1'b1;
            end
            r.read_word = stat;
            r.read_valid = 1'b1;
            pending_fn = FN_NONE;
          end
        end else if (io_mode_code(pending_fn)) begin
          // I/O mode repeats on every phase, full or empty, while linked
          if (unit_linked()) begin
            r.cmd = CMD_IO;
            r.target = linked_unit;
            r.unit_word = pending_fn & MODE_MASK;
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offers queued items with random gaps, none under no_idle. The
  // model advances on acceptance so its state follows the DUT item by item.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(decode_item(in_flight));
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (stim_items.size() != 0) begin
          in_flight = stim_items.pop_front();
          in_op <= in_flight.op;
          in_word <= in_flight.word;
          in_unit_interrupts <= in_flight.intr;
          in_valid <= 1'b1;
          send_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: checks each result against the oldest prediction, then
  // draws how long to stall before taking the next one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.reply = reply_t'(out_reply);
        got.cmd = cmd_t'(out_unit_command);
        got.target = out_target_unit;
        got.unit_word = out_unit_word;
        got.read_word = out_read_word;
        got.read_valid = out_read_valid;
        got.consumed = out_word_consumed;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result at %0t: reply %0d cmd %0d", $time,
                     got.reply, got.cmd);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch at %0t (expected/actual): reply %0d/%0d cmd %0d/%0d",
                       $time, want.reply, got.reply, want.cmd, got.cmd);
              $display("  target %0d/%0d unit word %o/%o read word %o/%o",
                       want.target, got.target, want.unit_word, got.unit_word,
                       want.read_word, got.read_word);
              $display("  read valid %0d/%0d consumed %0d/%0d",
                       want.read_valid, got.read_valid, want.consumed, got.consumed);
            end
          end
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off, once: the sender keeps pushing so both DUT
  // stages fill and in_ready drops.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake or register access.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input logic [1:0] op, input logic [WORD_W-1:0] word,
                           input logic [NUM_UNITS-1:0] intr);
    item_t it;
    it.op = op;
    it.word = word;
    it.intr = intr;
    stim_items.push_back(it);
  endtask

  // setup cycle, then access cycle; the write lands at the access edge
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_UNITS) units_on = data[NUM_UNITS-1:0];
    else conv_on = data[0];
  endtask

  // both registers, then step to a falling edge before queuing items
  task automatic set_config(input logic [NUM_UNITS-1:0] units, input logic conf);
    write_reg(ADDR_UNITS, {24'd0, units});
    write_reg(ADDR_CONFIG, {31'd0, conf});
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (stim_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One short well-formed exchange with random content, or some noise.
  task automatic add_sequence();
    int               kind;
    int               reps;
    logic [2:0]       dev;
    logic [8:0]       low9;
    logic [5:0]       low6;
    logic [2:0]       mode;
    kind = $urandom_range(0, 15);
    dev = 3'($urandom_range(4, 7));
    low9 = 9'($urandom_range(0, 511));
    low6 = 6'($urandom_range(0, 63));
    mode = 3'($urandom_range(3, 6));
    case (kind)
      0, 1, 2: begin
        push_item(OP_FUNC, {dev, low9}, rand_intr());
      end
      3, 4: begin
        push_item(OP_FUNC, {3'd0, low9}, rand_intr());
      end
      5, 6: begin
        push_item(OP_FUNC, FN_CONN_DATA, rand_intr());
        if ($urandom_range(0, 3) == 0) push_item(OP_EMPTY, rand_word(), rand_intr());
        push_item(OP_FULL, rand_word(), rand_intr());
      end
      7, 8: begin
        push_item(OP_FUNC, FN_FUNC_DATA, rand_intr());
        push_item(OP_FULL, rand_word(), rand_intr());
      end
      9, 10: begin
        push_item(OP_FUNC, FN_STATUS, rand_intr());
        if ($urandom_range(0, 3) == 0) push_item(OP_FULL, rand_word(), rand_intr());
        push_item(OP_EMPTY, rand_word(), rand_intr());
      end
      11, 12: begin
        push_item(OP_FUNC, {3'd1, mode, low6}, rand_intr());
        reps = $urandom_range(1, 4);
        repeat (reps) push_item($urandom_range(0, 1) ? OP_FULL : OP_EMPTY,
                                rand_word(), rand_intr());
      end
      13: begin
        push_item(OP_FUNC, $urandom_range(0, 1) ? FN_MCLEAR : FN_SELECT, rand_intr());
      end
      14: begin
        // deselected: everything but select is declined
        push_item(OP_FUNC, FN_DESELECT, rand_intr());
        push_item(OP_FUNC, rand_word(), rand_intr());
        if ($urandom_range(0, 3) != 0) push_item(OP_FUNC, FN_SELECT, rand_intr());
      end
      default: begin
        reps = $urandom_range(1, 3);
        repeat (reps) push_item(2'($urandom_range(0, 3)), rand_word(), rand_intr());
      end
    endcase
  endtask

  task automatic random_phase(input logic [NUM_UNITS-1:0] units, input logic conf,
                              input int count, input logic fast);
    set_config(units, conf);
    no_idle = fast;
    while (stim_items.size() < count) add_sequence();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // units 1 and 3 missing
    set_config(8'hF5, 1'b1);
    push_item(OP_FUNC,  FN_SELECT,    8'h00);
    push_item(OP_FUNC,  12'o4000,     8'hFF);  // direct connect unit 4
    push_item(OP_FUNC,  FUNC_MASK,    8'h00);  // largest nine-bit function
    push_item(OP_FUNC,  FN_NONE,      8'h00);
    push_item(OP_FUNC,  IO_MODE_LO,   8'h00);  // I/O mode pending
    push_item(OP_FULL,  12'o7777,     8'hFF);  // I/O phase, full
    push_item(OP_EMPTY, 12'o0000,     8'h00);  // I/O phase, empty
    push_item(OP_FUNC,  12'o1277,     8'h00);  // undefined code, sets reject
    push_item(OP_FUNC,  FN_STATUS,    8'h00);
    push_item(OP_FULL,  12'o5555,     8'h00);  // wrong phase for a status read
    push_item(OP_EMPTY, 12'o0000,     8'hFF);  // status with reject and interrupts
    push_item(OP_FUNC,  FN_CONN_DATA, 8'h00);
    push_item(OP_FULL,  12'o3000,     8'h00);  // missing unit: connect stays pending
    push_item(OP_FULL,  12'o7777,     8'h00);  // connect unit 7
    push_item(OP_FUNC,  FN_FUNC_DATA, 8'h00);
    push_item(OP_FULL,  12'o7777,     8'h00);
    push_item(OP_FUNC,  12'o3777,     8'h00);  // undefined top digit
    push_item(OP_FUNC,  FN_MCLEAR,    8'h00);
    push_item(OP_FUNC,  FN_FUNC_DATA, 8'h00);
    push_item(OP_FULL,  12'o0123,     8'h00);  // function phase with nothing linked
    push_item(OP_FUNC,  IO_MODE_HI,   8'h00);  // I/O mode with nothing linked
    push_item(OP_EMPTY, 12'o0000,     8'h00);  // nothing pending
    push_item(OP_SPARE, 12'o7777,     8'hFF);
    push_item(OP_FUNC,  FN_DESELECT,  8'h00);
    push_item(OP_FUNC,  FN_STATUS,    8'h00);  // declined while deselected
    push_item(OP_FUNC,  FN_SELECT,    8'h00);
    wait_drained();

    // converter absent: every function declined
    set_config(8'hF5, 1'b0);
    push_item(OP_FUNC, FN_SELECT, 8'h00);
    push_item(OP_FUNC, 12'o4000,  8'h00);
    push_item(OP_FULL, 12'o1234,  8'hFF);
    wait_drained();

    // link unit 6 with an I/O mode pending, then remove the unit
    set_config(8'hFF, 1'b1);
    push_item(OP_FUNC, FN_SELECT, 8'h00);
    push_item(OP_FUNC, 12'o6000,  8'h00);
    push_item(OP_FUNC, 12'o1477,  8'h00);
    wait_drained();
    set_config(8'h3F, 1'b1);
    push_item(OP_FULL,  12'o7777,     8'hFF);  // I/O phase, unit gone: no command
    push_item(OP_EMPTY, 12'o0000,     8'h00);
    push_item(OP_FUNC,  12'o0123,     8'h00);  // linked unit gone: reject
    push_item(OP_FUNC,  FN_FUNC_DATA, 8'h00);
    push_item(OP_FULL,  12'o4321,     8'h00);
    wait_drained();

    random_phase(8'hFF, 1'b1, 300, 1'b0);
    wait_drained();
    // back-to-back traffic with one long receiver stall in the middle
    random_phase(8'hFF, 1'b1, 200, 1'b1);
    repeat (20) @(negedge clk);
    hold_req = 1'b1;
    wait_drained();
    random_phase(8'h00, 1'b1, 150, 1'b0);
    wait_drained();
    random_phase(rand_intr(), 1'b1, 300, 1'b0);
    wait_drained();
    random_phase(8'hFF, 1'b0, 60, 1'b0);
    wait_drained();
    random_phase(rand_intr(), 1'b1, 300, 1'b0);
    wait_drained();
    random_phase(8'hF0, 1'b1, 300, 1'b1);
    wait_drained();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ccfd_pkg.sv
rtl/core/ccfd_cfg.sv
rtl/core/ccfd_decode.sv
rtl/core/channel_converter_function_decoder_core.sv
dv/tb_channel_converter_function_decoder_core.sv
